FILE: rtl/swsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsg_pkg
// Shared types and constants for the wavelet sample generator pipeline.
// ----------------------------------------------------------------------------
package swsg_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_KIND   = 3'd0;
  localparam logic [2:0] CFG_LENGTH = 3'd1;
  localparam logic [2:0] CFG_SCALE  = 3'd2;
  localparam logic [2:0] CFG_STEP   = 3'd3;

  localparam logic [10:0] LENGTH_RESET = 11'd1024;
  localparam logic [31:0] SCALE_RESET  = 32'd4294967;
  localparam logic [31:0] STEP_RESET   = 32'd4294967;

  // fixed point constants
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [63:0] LN2_RECIP_FULL = (64'd1 << 48) / 64'd2977044472;
  localparam logic [16:0] LN2_RECIP = LN2_RECIP_FULL[16:0];

  // pipeline shape
  localparam int SERIES_TERMS = 12;
  localparam int FRONT_STAGES = 5;
  localparam int TERM_STAGES  = 3;
  localparam int TAIL_STAGES  = 3;
  localparam int LATENCY      = FRONT_STAGES + SERIES_TERMS * TERM_STAGES + TAIL_STAGES;

  // side information that rides along with the exponential series
  typedef struct packed {
    logic        zero;  // sample forced to zero
    logic        neg;   // sign of the final sample
    logic [5:0]  q;     // power of two part of the exponent
    logic [41:0] b;     // second factor of the final product
  } side_t;

endpackage

FILE: rtl/swsg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsg_front
// Centring, exponent x = k*n^2, second factor and reduction of x by ln 2.
// ----------------------------------------------------------------------------
module swsg_front import swsg_pkg::*; #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [9:0]  sample_position,
  input  logic        wavelet_kind,
  input  logic [10:0] wavelet_length,
  input  logic [31:0] exponent_scale,
  input  logic [31:0] time_step,
  output logic        out_valid,
  output logic [31:0] out_r,
  output side_t       out_side
);

  localparam int LEN_CAP = (MAX_LENGTH > 2047) ? 2047 : MAX_LENGTH;
  localparam logic [10:0] LEN_CAP_V = 11'(LEN_CAP);

  logic [10:0] len;
  logic [9:0]  half;
  logic        outside;
  logic        n_neg_c;

  // stage 0
  logic        v0, kind0, zero0, nneg0;
  logic [9:0]  magn0;
  // stage 1
  logic        v1, kind1, zero1, nneg1;
  logic [19:0] sq1;
  logic [41:0] nt1;
  // stage 2
  logic        v2, kind2, zero2, nneg2;
  logic [51:0] x2;
  logic [41:0] nt2;
  // stage 3
  logic        v3;
  logic [36:0] x3;
  logic [5:0]  qe3;
  side_t       side3;
  logic [37:0] twox;
  logic [41:0] b_next;
  logic        neg_next;
  logic [37:0] qe_prod;
  // stage 4
  logic [37:0] r0;
  logic [31:0] r_fix;
  side_t       side_fix;

  always_comb begin
    len = (wavelet_length > LEN_CAP_V) ? LEN_CAP_V : wavelet_length;
    half = len[10:1];
    outside = ({1'b0, sample_position} >= len) ||
              (len[0] && ({1'b0, sample_position} == len - 11'd1));
    n_neg_c = sample_position < half;
  end

  always_ff @(posedge clk) begin
    v0    <= rst ? 1'b0 : in_valid;
    kind0 <= wavelet_kind;
    zero0 <= outside;
    nneg0 <= n_neg_c;
    magn0 <= n_neg_c ? half - sample_position : sample_position - half;
  end

  always_ff @(posedge clk) begin
    v1    <= rst ? 1'b0 : v0;
    kind1 <= kind0;
    zero1 <= zero0;
    nneg1 <= nneg0;
    sq1   <= magn0 * magn0;
    nt1   <= 42'(magn0) * 42'(time_step);
  end

  always_ff @(posedge clk) begin
    v2    <= rst ? 1'b0 : v1;
    kind2 <= kind1;
    zero2 <= zero1;
    nneg2 <= nneg1;
    x2    <= 52'(exponent_scale) * 52'(sq1);
    nt2   <= nt1;
  end

  // second factor and estimate of x / ln 2 (may be one short)
  always_comb begin
    twox = {x2[36:0], 1'b0};
    if (!kind2) begin
      if (twox <= 38'(ONE_Q32)) begin
        b_next = 42'(38'(ONE_Q32) - twox);
        neg_next = 1'b0;
      end else begin
        b_next = 42'(twox - 38'(ONE_Q32));
        neg_next = 1'b1;
      end
    end else begin
      b_next = nt2;
      neg_next = !nneg2;
    end
  end

  assign qe_prod = 38'(x2[36:16]) * 38'(LN2_RECIP);

  always_ff @(posedge clk) begin
    v3         <= rst ? 1'b0 : v2;
    x3         <= x2[36:0];
    qe3        <= qe_prod[37:32];
    side3.zero <= zero2 || (x2[51:37] != 15'd0);
    side3.neg  <= neg_next;
    side3.q    <= 6'd0;
    side3.b    <= b_next;
  end

  // remainder with one correction step
  assign r0 = 38'(x3) - 38'(qe3) * 38'(LN2_Q32);

  always_comb begin
    side_fix = side3;
    if (r0 >= 38'(LN2_Q32)) begin
      r_fix      = 32'(r0 - 38'(LN2_Q32));
      side_fix.q = qe3 + 6'd1;
    end else begin
      r_fix      = r0[31:0];
      side_fix.q = qe3;
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= rst ? 1'b0 : v3;
    out_r     <= r_fix;
    out_side  <= side_fix;
  end

endmodule

FILE: rtl/swsg_exp_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsg_exp_term
// One Horner step of the exp(-r) series: e = 1 - floor(floor(r*e)/j).
// ----------------------------------------------------------------------------
module swsg_exp_term import swsg_pkg::*; #(
  parameter int J = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] in_r,
  input  logic [32:0] in_e,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_r,
  output logic [32:0] out_e,
  output side_t       out_side
);

  localparam int L = $clog2(J);
  localparam logic [63:0] MUL_FULL = ((64'd1 << (32 + L)) + 64'(J) - 64'd1) / 64'(J);
  localparam logic [32:0] MUL = MUL_FULL[32:0];

  logic [64:0] prod;
  logic        va, vb;
  logic [31:0] ra, rb;
  side_t       sa, sb;
  logic [31:0] pa;
  logic [48:0] ph;
  logic [47:0] pl;
  logic [65:0] sum;
  logic [32:0] quo;

  assign prod = 65'(in_r) * 65'(in_e);

  always_ff @(posedge clk) begin
    va <= rst ? 1'b0 : in_valid;
    ra <= in_r;
    sa <= in_side;
    pa <= prod[63:32];
  end

  // divide by j as a reciprocal product, split in two halves
  always_ff @(posedge clk) begin
    vb <= rst ? 1'b0 : va;
    rb <= ra;
    sb <= sa;
    ph <= 49'(pa) * 49'(MUL[32:16]);
    pl <= 48'(pa) * 48'(MUL[15:0]);
  end

  always_comb begin
    sum = (66'(ph) << 16) + 66'(pl);
    quo = 33'(sum >> (32 + L));
  end

  always_ff @(posedge clk) begin
    out_valid <= rst ? 1'b0 : vb;
    out_r     <= rb;
    out_side  <= sb;
    out_e     <= ONE_Q32 - quo;
  end

endmodule

FILE: rtl/swsg_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsg_tail
// Power of two scaling of exp(-r), final product, rounding and sign.
// ----------------------------------------------------------------------------
module swsg_tail import swsg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [32:0]        in_e,
  input  side_t              in_side,
  output logic               done,
  output logic signed [47:0] sample_value
);

  logic [46:0] sh_sum;
  logic        va, vb;
  logic [32:0] ea;
  side_t       sa;
  logic        negb;
  logic [53:0] ph;
  logic [53:0] pl;
  logic [75:0] sum;
  logic [47:0] mag;

  always_comb begin
    if (in_side.q == 6'd0) begin
      sh_sum = 47'(in_e);
    end else begin
      sh_sum = (47'(in_e) + (47'd1 << (in_side.q - 6'd1))) >> in_side.q;
    end
  end

  always_ff @(posedge clk) begin
    va <= rst ? 1'b0 : in_valid;
    sa <= in_side;
    ea <= in_side.zero ? 33'd0 : sh_sum[32:0];
  end

  always_ff @(posedge clk) begin
    vb   <= rst ? 1'b0 : va;
    negb <= sa.neg;
    ph   <= 54'(ea) * 54'(sa.b[41:21]);
    pl   <= 54'(ea) * 54'(sa.b[20:0]);
  end

  // magnitude stays below 2^40, so no saturation is reached
  always_comb begin
    sum = (76'(ph) << 21) + 76'(pl) + (76'd1 << 33);
    mag = 48'(sum >> 34);
  end

  always_ff @(posedge clk) begin
    done         <= rst ? 1'b0 : vb;
    sample_value <= negb ? -$signed(mag) : $signed(mag);
  end

endmodule

FILE: rtl/seismic_wavelet_sample_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seismic_wavelet_sample_generator_core
// Ricker / first Gaussian derivative wavelet sample generator, fully pipelined.
// ----------------------------------------------------------------------------
// one sample position may be started every clock cycle while busy is low;
// each transaction returns its sample at the end of the pipeline, flagged
// by done for one cycle, in start order. the pipeline has five stages for
// centring, the k*n^2 product and the reduction of x by ln 2, three stages
// for each of the twelve terms of the exp series (multiply, reciprocal
// divide, subtract) and three for scaling, the final product and rounding.
// done cannot be held off, so results must be taken as they come. busy is
// a registered copy of reset and is low otherwise. configuration is to be
// written while no transaction is in flight
module seismic_wavelet_sample_generator_core import swsg_pkg::*; #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         sample_position,
  output logic               done,
  output logic signed [47:0] sample_value,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic        wavelet_kind;
  logic [10:0] wavelet_length;
  logic [31:0] exponent_scale;
  logic [31:0] time_step;
  logic        accept;

  logic        tv [SERIES_TERMS+1];
  logic [31:0] tr [SERIES_TERMS+1];
  logic [32:0] te [SERIES_TERMS+1];
  side_t       ts [SERIES_TERMS+1];

  // busy is a registered copy of reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      wavelet_kind   <= 1'b0;
      wavelet_length <= LENGTH_RESET;
      exponent_scale <= SCALE_RESET;
      time_step      <= STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KIND:   wavelet_kind   <= cfg_data[0];
        CFG_LENGTH: wavelet_length <= cfg_data[10:0];
        CFG_SCALE:  exponent_scale <= cfg_data;
        CFG_STEP:   time_step      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // centring, exponent and range reduction
  swsg_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .sample_position(sample_position),
    .wavelet_kind   (wavelet_kind),
    .wavelet_length (wavelet_length),
    .exponent_scale (exponent_scale),
    .time_step      (time_step),
    .out_valid      (tv[0]),
    .out_r          (tr[0]),
    .out_side       (ts[0])
  );

  // series starts from e = 1.0
  assign te[0] = ONE_Q32;

  // horner chain, j from twelve down to one
  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
    swsg_exp_term #(.J(SERIES_TERMS - i)) u_term (
      .clk      (clk),
      .rst      (rst),
      .in_valid (tv[i]),
      .in_r     (tr[i]),
      .in_e     (te[i]),
      .in_side  (ts[i]),
      .out_valid(tv[i+1]),
      .out_r    (tr[i+1]),
      .out_e    (te[i+1]),
      .out_side (ts[i+1])
    );
  end

  // scaling by 2^-q, final product and sign
  swsg_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (tv[SERIES_TERMS]),
    .in_e        (te[SERIES_TERMS]),
    .in_side     (ts[SERIES_TERMS]),
    .done        (done),
    .sample_value(sample_value)
  );

  // every result comes from a start exactly one latency earlier
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching start");

  // every start yields a result after the latency
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    $past(accept, LATENCY) && !$past(rst, LATENCY) |-> done)
    else $error("start lost in pipeline");

  // the block never refuses a start unless the registered reset is high
  a_never_busy: assert property (@(posedge clk)
    $past(!rst) |-> !busy)
    else $error("busy outside reset");

endmodule
